FILE: sv/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, quiet while reset is held
`define RC4SC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Concurrent check that also runs through reset
`define RC4SC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: sv/rc4sc_pkg.sv
package rc4sc_pkg;

    // Permutation geometry, fixed by the cipher
    localparam int PERM_AW    = 8;
    localparam int PERM_DEPTH = 256;

    // Default key store depth
    localparam int DEFAULT_MAX_KEY_BYTES = 256;

    typedef logic [PERM_AW-1:0] byte_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_D_FETCH_K,
        ST_D_FETCH_B,
        ST_D_RESOLVE,
        ST_K_CLEAR,
        ST_K_READ,
        ST_K_MIX,
        ST_K_SWAP,
        ST_K_WB
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic data_start;   // data item taken: step i, read S[i+1]
        logic key_store;    // key item taken: store byte if room
        logic fetch_k;      // take a, step k, read S[k]
        logic fetch_b;      // take b, write S[i]=b, read S[a+b]
        logic resolve;      // write S[k]=a, load result
        logic sched_clear;  // drop permutation to identity, clear loop
        logic sched_read;   // read S[n] and key byte
        logic sched_mix;    // update mix, read S[mix]
        logic sched_swap;   // write S[n]=S[mix]
        logic sched_wb;     // write S[mix]=S[n], advance n, read next
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;     // result register can take a new item
        logic n_last;       // schedule is on its final entry
    } status_t;

endpackage

FILE: sv/rc4_stream_cipher_core.sv
// Data item: result loaded after the fetch-k, fetch-b and resolve states; the next item
// can be taken in resolve, which waits for a free result register (read S[i], read S[k],
// swap and keystream read on the permutation RAM ports). Last key item adds a schedule
// (clear, read, three steps per entry; one permutation RAM write port), input closed.
// Reset (aresetn, synchronous, active low): permutation reads as identity, stream
// indices and key count zero, no result pending; the key store keeps its contents.
module rc4_stream_cipher_core #(
    parameter int MAX_KEY_BYTES = rc4sc_pkg::DEFAULT_MAX_KEY_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_value,
    input  logic        s_key_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte
);

    rc4sc_pkg::cmd_t    cmd;
    rc4sc_pkg::status_t status;

    rc4sc_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_action   (s_action),
        .s_key_last (s_key_last),
        .s_ready    (s_ready),
        .status     (status),
        .cmd        (cmd)
    );

    rc4sc_datapath #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .s_value    (s_value),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_out_byte (m_out_byte)
    );

endmodule

FILE: sv/rc4sc_perm_ram.sv
module rc4sc_perm_ram (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  clr,
    input  logic                  we,
    input  rc4sc_pkg::byte_t      waddr,
    input  rc4sc_pkg::byte_t      wdata,
    input  logic                  re0,
    input  rc4sc_pkg::byte_t      raddr0,
    output rc4sc_pkg::byte_t      rdata0,
    input  logic                  re1,
    input  rc4sc_pkg::byte_t      raddr1,
    output rc4sc_pkg::byte_t      rdata1
);

    rc4sc_pkg::byte_t                      mem [rc4sc_pkg::PERM_DEPTH];
    logic [rc4sc_pkg::PERM_DEPTH-1:0]      vld_reg;
    rc4sc_pkg::byte_t                      r0_data_reg;
    rc4sc_pkg::byte_t                      r0_addr_reg;
    logic                                  r0_vld_reg;
    rc4sc_pkg::byte_t                      r1_data_reg;
    rc4sc_pkg::byte_t                      r1_addr_reg;
    logic                                  r1_vld_reg;

    // Entry valid bits: an entry never written since clear reads as its index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (clr) begin
            vld_reg <= '0;
        end else if (we) begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read ports, write data forwarded on address match
    always_ff @(posedge aclk) begin
        if (re0) begin
            r0_addr_reg <= raddr0;
            if (we && (waddr == raddr0)) begin
                r0_data_reg <= wdata;
                r0_vld_reg  <= 1'b1;
            end else begin
                r0_data_reg <= mem[raddr0];
                r0_vld_reg  <= vld_reg[raddr0];
            end
        end
        if (re1) begin
            r1_addr_reg <= raddr1;
            if (we && (waddr == raddr1)) begin
                r1_data_reg <= wdata;
                r1_vld_reg  <= 1'b1;
            end else begin
                r1_data_reg <= mem[raddr1];
                r1_vld_reg  <= vld_reg[raddr1];
            end
        end
    end

    assign rdata0 = r0_vld_reg ? r0_data_reg : r0_addr_reg;
    assign rdata1 = r1_vld_reg ? r1_data_reg : r1_addr_reg;

endmodule

FILE: sv/rc4sc_datapath.sv
module rc4sc_datapath #(
    parameter int MAX_KEY_BYTES = rc4sc_pkg::DEFAULT_MAX_KEY_BYTES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rc4sc_pkg::cmd_t       cmd,
    output rc4sc_pkg::status_t    status,
    input  logic [7:0]            s_value,
    input  logic                  m_ready,
    output logic                  m_valid,
    output logic [7:0]            m_out_byte
);

    localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int CNT_W  = $clog2(MAX_KEY_BYTES + 1);

    // Stream and schedule state
    rc4sc_pkg::byte_t    i_reg;
    rc4sc_pkg::byte_t    k_reg;
    rc4sc_pkg::byte_t    n_reg;
    rc4sc_pkg::byte_t    mix_reg;
    logic [KEY_AW-1:0]   kpos_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                out_vld_reg;

    // Item payload held across the steps
    rc4sc_pkg::byte_t    a_reg;
    rc4sc_pkg::byte_t    t_reg;
    rc4sc_pkg::byte_t    sn_reg;
    rc4sc_pkg::byte_t    val_reg;
    rc4sc_pkg::byte_t    out_reg;
    rc4sc_pkg::byte_t    key_rd_reg;
    rc4sc_pkg::byte_t    key_mem [MAX_KEY_BYTES];

    // Permutation port signals
    logic                p_we;
    rc4sc_pkg::byte_t    p_waddr;
    rc4sc_pkg::byte_t    p_wdata;
    logic                p_re0;
    rc4sc_pkg::byte_t    p_raddr0;
    rc4sc_pkg::byte_t    p_rd0;
    logic                p_re1;
    rc4sc_pkg::byte_t    p_raddr1;
    rc4sc_pkg::byte_t    p_rd1;

    logic                key_room;
    logic                key_re;
    logic [KEY_AW-1:0]   key_raddr;
    logic [CNT_W-1:0]    kpos_inc;
    logic [KEY_AW-1:0]   kpos_next;
    rc4sc_pkg::byte_t    kb;
    rc4sc_pkg::byte_t    mix_next;
    rc4sc_pkg::byte_t    ks;
    logic                n_last;

    rc4sc_perm_ram u_perm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (cmd.sched_clear),
        .we      (p_we),
        .waddr   (p_waddr),
        .wdata   (p_wdata),
        .re0     (p_re0),
        .raddr0  (p_raddr0),
        .rdata0  (p_rd0),
        .re1     (p_re1),
        .raddr1  (p_raddr1),
        .rdata1  (p_rd1)
    );

    // Key schedule arithmetic
    assign key_room  = (cnt_reg < CNT_W'(MAX_KEY_BYTES));
    assign kpos_inc  = CNT_W'(kpos_reg) + CNT_W'(1);
    assign kpos_next = (kpos_inc >= cnt_reg) ? '0 : kpos_inc[KEY_AW-1:0];
    assign kb        = (cnt_reg != '0) ? key_rd_reg : 8'd0;
    assign mix_next  = mix_reg + p_rd0 + kb;
    assign n_last    = (n_reg == 8'hFF);

    // Keystream byte: S[k] still holds its old value in the memory
    assign ks = (t_reg == k_reg) ? a_reg : p_rd1;

    // Route permutation read and write ports by step
    always_comb begin
        p_re0    = 1'b0;
        p_raddr0 = n_reg;
        p_we     = 1'b0;
        p_waddr  = n_reg;
        p_wdata  = p_rd0;
        priority if (cmd.data_start) begin
            p_re0    = 1'b1;
            p_raddr0 = i_reg + 8'd1;
        end else if (cmd.fetch_k) begin
            p_re0    = 1'b1;
            p_raddr0 = k_reg + p_rd0;
        end else if (cmd.sched_read) begin
            p_re0    = 1'b1;
            p_raddr0 = n_reg;
        end else if (cmd.sched_mix) begin
            p_re0    = 1'b1;
            p_raddr0 = mix_next;
        end else if (cmd.sched_wb) begin
            p_re0    = 1'b1;
            p_raddr0 = n_reg + 8'd1;
        end else begin
            p_re0    = 1'b0;
        end
        priority if (cmd.fetch_b) begin
            p_we    = 1'b1;
            p_waddr = i_reg;
            p_wdata = p_rd0;
        end else if (cmd.resolve) begin
            p_we    = 1'b1;
            p_waddr = k_reg;
            p_wdata = a_reg;
        end else if (cmd.sched_swap) begin
            p_we    = 1'b1;
            p_waddr = n_reg;
            p_wdata = p_rd0;
        end else if (cmd.sched_wb) begin
            p_we    = 1'b1;
            p_waddr = mix_reg;
            p_wdata = sn_reg;
        end else begin
            p_we    = 1'b0;
        end
    end

    assign p_re1    = cmd.fetch_b;
    assign p_raddr1 = a_reg + p_rd0;

    // Key store read address
    assign key_re    = cmd.sched_read | cmd.sched_wb;
    assign key_raddr = cmd.sched_wb ? kpos_next : kpos_reg;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg       <= '0;
            k_reg       <= '0;
            n_reg       <= '0;
            mix_reg     <= '0;
            kpos_reg    <= '0;
            cnt_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            if (cmd.data_start) begin
                i_reg <= i_reg + 8'd1;
            end
            if (cmd.fetch_k) begin
                k_reg <= k_reg + p_rd0;
            end
            if (cmd.key_store && key_room) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.sched_clear) begin
                n_reg    <= '0;
                mix_reg  <= '0;
                kpos_reg <= '0;
            end
            if (cmd.sched_mix) begin
                mix_reg <= mix_next;
            end
            if (cmd.sched_wb) begin
                n_reg    <= n_reg + 8'd1;
                kpos_reg <= kpos_next;
                // restart the stream once the schedule finishes
                if (n_last) begin
                    i_reg   <= '0;
                    k_reg   <= '0;
                    cnt_reg <= '0;
                end
            end
            if (cmd.resolve) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload capture
    always_ff @(posedge aclk) begin
        if (cmd.data_start) begin
            val_reg <= s_value;
        end
        if (cmd.fetch_k) begin
            a_reg <= p_rd0;
        end
        if (cmd.fetch_b) begin
            t_reg <= a_reg + p_rd0;
        end
        if (cmd.sched_mix) begin
            sn_reg <= p_rd0;
        end
        if (cmd.resolve) begin
            out_reg <= val_reg ^ ks;
        end
    end

    // Key store
    always_ff @(posedge aclk) begin
        if (cmd.key_store && key_room) begin
            key_mem[cnt_reg[KEY_AW-1:0]] <= s_value;
        end
        if (key_re) begin
            key_rd_reg <= key_mem[key_raddr];
        end
    end

    assign status.out_free = !out_vld_reg || m_ready;
    assign status.n_last   = n_last;
    assign m_valid         = out_vld_reg;
    assign m_out_byte      = out_reg;

endmodule

FILE: sv/rc4sc_ctrl.sv
module rc4sc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_action,
    input  logic                  s_key_last,
    output logic                  s_ready,
    input  rc4sc_pkg::status_t    status,
    output rc4sc_pkg::cmd_t       cmd
);

    rc4sc_pkg::state_t state_reg;
    rc4sc_pkg::state_t state_next;
    logic              open;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rc4sc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        open       = 1'b0;
        unique case (state_reg)
            rc4sc_pkg::ST_IDLE: begin
                open = 1'b1;
            end
            rc4sc_pkg::ST_D_FETCH_K: begin
                cmd.fetch_k = 1'b1;
                state_next  = rc4sc_pkg::ST_D_FETCH_B;
            end
            rc4sc_pkg::ST_D_FETCH_B: begin
                cmd.fetch_b = 1'b1;
                state_next  = rc4sc_pkg::ST_D_RESOLVE;
            end
            rc4sc_pkg::ST_D_RESOLVE: begin
                // hold until the result register is free
                if (status.out_free) begin
                    cmd.resolve = 1'b1;
                    open        = 1'b1;
                    state_next  = rc4sc_pkg::ST_IDLE;
                end
            end
            rc4sc_pkg::ST_K_CLEAR: begin
                cmd.sched_clear = 1'b1;
                state_next      = rc4sc_pkg::ST_K_READ;
            end
            rc4sc_pkg::ST_K_READ: begin
                cmd.sched_read = 1'b1;
                state_next     = rc4sc_pkg::ST_K_MIX;
            end
            rc4sc_pkg::ST_K_MIX: begin
                cmd.sched_mix = 1'b1;
                state_next    = rc4sc_pkg::ST_K_SWAP;
            end
            rc4sc_pkg::ST_K_SWAP: begin
                cmd.sched_swap = 1'b1;
                state_next     = rc4sc_pkg::ST_K_WB;
            end
            rc4sc_pkg::ST_K_WB: begin
                cmd.sched_wb = 1'b1;
                state_next   = status.n_last ? rc4sc_pkg::ST_IDLE : rc4sc_pkg::ST_K_MIX;
            end
            default: begin
                state_next = rc4sc_pkg::ST_IDLE;
            end
        endcase

        // Take the next item when the block is open
        s_ready = open;
        if (open && s_valid) begin
            if (s_action) begin
                cmd.data_start = 1'b1;
                state_next     = rc4sc_pkg::ST_D_FETCH_K;
            end else begin
                cmd.key_store = 1'b1;
                state_next    = s_key_last ? rc4sc_pkg::ST_K_CLEAR : rc4sc_pkg::ST_IDLE;
            end
        end
    end

endmodule

FILE: sv/rc4sc_checker.sv
`include "assert_macros.svh"

module rc4sc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_action,
    input  logic        s_key_last,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_byte
);

    logic data_take;
    logic sched_take;
    logic out_stall;

    // Handshake events seen on the ports
    assign data_take  = s_valid && s_ready && s_action;
    assign sched_take = s_valid && s_ready && !s_action && s_key_last;
    assign out_stall  = m_valid && !m_ready;

    // A stalled result holds
    `RC4SC_ASSERT(a_out_hold, out_stall |=> (m_valid && $stable(m_out_byte)), "result moved")

    // No result survives reset
    `RC4SC_ASSERT_ALWAYS(a_rst_clear, (!aresetn) |=> (!m_valid), "result pending after reset")

    // A data item keeps the input closed while it works
    `RC4SC_ASSERT(a_data_busy, data_take |=> (!s_ready), "input open in data item")

    // The last key byte starts the schedule, which blocks the input
    `RC4SC_ASSERT(a_sched_busy, sched_take |=> (!s_ready ##1 !s_ready), "input open in schedule")

endmodule

bind rc4_stream_cipher_core rc4sc_checker u_rc4sc_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_action   (s_action),
    .s_key_last (s_key_last),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_byte (m_out_byte)
);

FILE: verif/rc4_stream_cipher_core_tb.sv
module rc4_stream_cipher_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  KEY_DEPTH      = rc4sc_pkg::DEFAULT_MAX_KEY_BYTES;
    localparam int  PERM_N         = rc4sc_pkg::PERM_DEPTH;
    localparam int  WATCHDOG_LIMIT = 5000;
    localparam int  DRAIN_CYCLES   = 800;
    localparam int  HOLD_CYCLES    = 300;
    localparam int  ITEM_TARGET    = 1150;
    localparam logic ACT_KEY       = 1'b0;
    localparam logic ACT_DATA      = 1'b1;

    logic       aclk;
    logic       aresetn    = 1'b0;
    logic       s_valid    = 1'b0;
    logic       s_ready;
    logic       s_action   = ACT_KEY;
    logic [7:0] s_value    = 8'h00;
    logic       s_key_last = 1'b0;
    logic       m_valid;
    logic       m_ready    = 1'b0;
    logic [7:0] m_out_byte;

    // Cipher state mirror
    rc4sc_pkg::byte_t perm_model [PERM_N];
    rc4sc_pkg::byte_t key_model  [KEY_DEPTH];
    int               key_fill;
    rc4sc_pkg::byte_t idx_i;
    rc4sc_pkg::byte_t idx_k;

    rc4sc_pkg::byte_t expected_bytes [$];

    int  items_sent    = 0;
    int  schedules_run = 0;
    int  bytes_checked = 0;
    int  mismatch_count = 0;
    bit  tx_idle_on    = 1'b1;
    bit  rx_idle_on    = 1'b1;
    int  rx_hold_req   = 0;

    rc4_stream_cipher_core #(
        .MAX_KEY_BYTES(KEY_DEPTH)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_value    (s_value),
        .s_key_last (s_key_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Mirror of the cipher state after reset
    function automatic void reset_cipher_model();
        for (int n = 0; n < PERM_N; n++) begin
            perm_model[n] = rc4sc_pkg::byte_t'(n);
        end
        key_fill = 0;
        idx_i    = '0;
        idx_k    = '0;
    endfunction

    // Rebuild the permutation from the stored key, then clear indices and count
    function automatic void run_key_schedule();
        int               len;
        int               kpos;
        rc4sc_pkg::byte_t mix;
        rc4sc_pkg::byte_t kb;
        rc4sc_pkg::byte_t tmp;
        len  = key_fill;
        kpos = 0;
        mix  = '0;
        for (int n = 0; n < PERM_N; n++) begin
            perm_model[n] = rc4sc_pkg::byte_t'(n);
        end
        for (int n = 0; n < PERM_N; n++) begin
            kb  = (len != 0) ? key_model[kpos] : rc4sc_pkg::byte_t'(0);
            mix = mix + perm_model[n] + kb;
            tmp = perm_model[n];
            perm_model[n]   = perm_model[mix];
            perm_model[mix] = tmp;
            kpos++;
            if (kpos >= len) kpos = 0;
        end
        idx_i    = '0;
        idx_k    = '0;
        key_fill = 0;
        schedules_run++;
    endfunction

    // Store a key byte if there is room; schedule on the last one
    function automatic void absorb_key_byte(rc4sc_pkg::byte_t val, logic last);
        if (key_fill < KEY_DEPTH) begin
            key_model[key_fill] = val;
            key_fill++;
        end
        if (last) run_key_schedule();
    endfunction

    // Advance the generator one step and return the ciphered byte
    function automatic rc4sc_pkg::byte_t cipher_byte(rc4sc_pkg::byte_t val);
        rc4sc_pkg::byte_t a;
        rc4sc_pkg::byte_t b;
        rc4sc_pkg::byte_t sum;
        idx_i = idx_i + 8'd1;
        idx_k = idx_k + perm_model[idx_i];
        a = perm_model[idx_i];
        b = perm_model[idx_k];
        perm_model[idx_i] = b;
        perm_model[idx_k] = a;
        sum = a + b;
        return val ^ perm_model[sum];
    endfunction

    // Mostly short pauses, now and then a long one
    function automatic int pause_length();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one item, wait for the handshake, predict, then maybe go idle
    task automatic send_item(input logic act, input rc4sc_pkg::byte_t val, input logic last);
        int               gap;
        rc4sc_pkg::byte_t pred;
        s_valid    <= 1'b1;
        s_action   <= act;
        s_value    <= val;
        s_key_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (act == ACT_DATA) begin
            pred = cipher_byte(val);
            expected_bytes.insert(expected_bytes.size(), pred);
        end else begin
            absorb_key_byte(val, last);
        end
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 99) < 35) gap = pause_length();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_key(input int len);
        for (int j = 0; j < len; j++) begin
            send_item(ACT_KEY, rc4sc_pkg::byte_t'($urandom_range(0, 255)), j == len - 1);
        end
    endtask

    // Drop the offer and hold the sender until every predicted byte has come back
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
    endtask

    // Receiver: random stalls, plus the long hold when requested
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req > 0) begin
                stall_left  = rx_hold_req;
                rx_hold_req = 0;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (rx_idle_on && $urandom_range(0, 99) < 20) stall_left = pause_length();
            end
        end
    end

    // Compare each accepted result with the oldest prediction
    initial begin : result_check
        rc4sc_pkg::byte_t want;
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %02h",
                             $time, m_out_byte);
                    mismatch_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    bytes_checked++;
                    if (m_out_byte !== want) begin
                        $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                                 $time, want, m_out_byte);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // End the run if nothing moves on either channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Data before any key runs on the identity permutation; key_last on data is ignored
    task automatic test_data_before_key();
        send_item(ACT_DATA, 8'h00, 1'b0);
        send_item(ACT_DATA, 8'hFF, 1'b0);
        send_item(ACT_DATA, 8'h5A, 1'b1);
        send_item(ACT_DATA, 8'hA5, 1'b0);
        wait_results_drained();
    endtask

    // One-byte keys at both extremes, then a short multi-byte key
    task automatic test_short_keys();
        send_item(ACT_KEY, 8'h00, 1'b1);
        send_item(ACT_DATA, 8'hFF, 1'b0);
        send_item(ACT_DATA, 8'h00, 1'b0);
        send_item(ACT_DATA, 8'h80, 1'b0);
        send_item(ACT_KEY, 8'hFF, 1'b1);
        send_item(ACT_DATA, 8'h01, 1'b0);
        send_item(ACT_DATA, 8'hFE, 1'b1);
        send_item(ACT_KEY, 8'h4B, 1'b0);
        send_item(ACT_KEY, 8'h65, 1'b0);
        send_item(ACT_KEY, 8'h79, 1'b1);
        send_item(ACT_DATA, 8'h50, 1'b0);
        send_item(ACT_DATA, 8'h6C, 1'b0);
        wait_results_drained();
    endtask

    // Key bytes stored mid-stream must not disturb the generator until the last one
    task automatic test_key_during_stream();
        send_item(ACT_KEY, 8'h13, 1'b0);
        send_item(ACT_DATA, 8'h37, 1'b0);
        send_item(ACT_KEY, 8'hC0, 1'b0);
        send_item(ACT_DATA, 8'hDE, 1'b0);
        send_item(ACT_DATA, 8'hAD, 1'b0);
        send_item(ACT_KEY, 8'h7E, 1'b1);
        send_item(ACT_DATA, 8'hBE, 1'b0);
        send_item(ACT_DATA, 8'hEF, 1'b0);
        wait_results_drained();
    endtask

    // Overflow the key store; the last byte is dropped but still schedules
    task automatic test_key_store_full();
        for (int j = 0; j < KEY_DEPTH + 4; j++) begin
            send_item(ACT_KEY, rc4sc_pkg::byte_t'($urandom_range(0, 255)), 1'b0);
        end
        send_item(ACT_KEY, rc4sc_pkg::byte_t'($urandom_range(0, 255)), 1'b1);
        for (int j = 0; j < 8; j++) begin
            send_item(ACT_DATA, rc4sc_pkg::byte_t'($urandom_range(0, 255)), 1'b0);
        end
        wait_results_drained();
    endtask

    // Hold the output for a long stretch while data keeps coming, then drain
    task automatic test_output_backpressure();
        tx_idle_on = 1'b0;
        send_key(5);
        rx_hold_req = HOLD_CYCLES;
        for (int j = 0; j < 40; j++) begin
            send_item(ACT_DATA, rc4sc_pkg::byte_t'($urandom_range(0, 255)), 1'b0);
        end
        wait_results_drained();
        tx_idle_on = 1'b1;
    endtask

    // Sessions of key then data, with stray key bytes and ignored key_last flags mixed in
    task automatic test_random_sessions();
        int klen;
        int ndata;
        int r;
        while (items_sent < ITEM_TARGET) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 70) klen = $urandom_range(1, 16);
            else if (r < 95) klen = $urandom_range(17, 64);
            else klen = $urandom_range(200, KEY_DEPTH);
            send_key(klen);
            ndata = $urandom_range(1, 40);
            for (int j = 0; j < ndata; j++) begin
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    send_item(ACT_KEY, rc4sc_pkg::byte_t'($urandom_range(0, 255)), 1'b0);
                end else if (r < 10) begin
                    send_item(ACT_DATA, rc4sc_pkg::byte_t'($urandom_range(0, 255)), 1'b1);
                end else begin
                    send_item(ACT_DATA, rc4sc_pkg::byte_t'($urandom_range(0, 255)), 1'b0);
                end
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        reset_cipher_model();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_data_before_key();
        test_short_keys();
        test_key_during_stream();
        test_key_store_full();
        test_output_backpressure();
        test_random_sessions();

        // Let any running schedule finish before closing
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run: %0d items sent, %0d key schedules, %0d ciphered bytes checked",
                 items_sent, schedules_run, bytes_checked);
        $display("Covered: data before any key, full key store, long output hold, %0d errors",
                 mismatch_count);
        if (mismatch_count == 0 && expected_bytes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/rc4sc_pkg.sv
sv/rc4sc_perm_ram.sv
sv/rc4sc_datapath.sv
sv/rc4sc_ctrl.sv
sv/rc4_stream_cipher_core.sv
sv/rc4sc_checker.sv
verif/rc4_stream_cipher_core_tb.sv
